>>> sv/sfab_pkg.sv
// types, constants and functions for the blitter write path
// no dependencies; imported by the top level

package sfab_pkg;

    typedef enum logic [1:0] {
        REQ_CTRL   = 2'd0,
        REQ_BLIT   = 2'd1,
        REQ_STATUS = 2'd2
    } t_req;

    localparam int         DATA_BITS   = 8;
    localparam int         CARRY_BITS  = 7;
    localparam int         WORD_BITS   = CARRY_BITS + DATA_BITS;
    localparam int         SHIFT_BITS  = DATA_BITS + 1;
    localparam logic [6:0] CARRY_RESET = 7'h7f;

    // mode byte layout
    localparam int MODE_HI_SEL  = 0;
    localparam int MODE_SH_LO   = 1;
    localparam int MODE_SH_HI   = 2;
    localparam int MODE_REVERSE = 3;
    localparam int MODE_FN_LO   = 4;
    localparam int MODE_FN_HI   = 7;

    function automatic logic [DATA_BITS-1:0] rev8(input logic [DATA_BITS-1:0] v);
        logic [DATA_BITS-1:0] r;
        for (int i = 0; i < DATA_BITS; i++) begin
            r[i] = v[DATA_BITS-1-i];
        end
        return r;
    endfunction

    // 74181 logic mode, active-high data, select s3..s0
    function automatic logic [DATA_BITS-1:0] logic181(input logic [3:0] sel,
                                                      input logic [DATA_BITS-1:0] a,
                                                      input logic [DATA_BITS-1:0] b);
        logic [DATA_BITS-1:0] f;
        case (sel)
            4'd0:    f = ~a;
            4'd1:    f = ~(a | b);
            4'd2:    f = ~a & b;
            4'd3:    f = '0;
            4'd4:    f = ~(a & b);
            4'd5:    f = ~b;
            4'd6:    f = a ^ b;
            4'd7:    f = a & ~b;
            4'd8:    f = ~a | b;
            4'd9:    f = ~(a ^ b);
            4'd10:   f = b;
            4'd11:   f = a & b;
            4'd12:   f = '1;
            4'd13:   f = a | ~b;
            4'd14:   f = a | b;
            default: f = a;
        endcase
        return f;
    endfunction

endpackage

>>> sv/sfab_req_if.sv
// request channel of the blitter write path
// valid/ready handshake with the bus request payload

interface sfab_req_if #(
    parameter int ADDR_BITS = 13
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           src_value;
    logic [7:0]           old_value;

    modport source (output valid, req_type, address, src_value, old_value, input ready);
    modport sink   (input valid, req_type, address, src_value, old_value, output ready);
endinterface

>>> sv/sfab_res_if.sv
// result channel of the blitter write path
// valid/ready handshake with the video RAM write and status payload

interface sfab_res_if #(
    parameter int ADDR_BITS = 13
);
    logic                 valid;
    logic                 ready;
    logic                 write_valid;
    logic [ADDR_BITS-1:0] write_addr;
    logic [7:0]           write_value;
    logic                 hit_status;

    modport source (output valid, write_valid, write_addr, write_value, hit_status,
                    input ready);
    modport sink   (input valid, write_valid, write_addr, write_value, hit_status,
                    output ready);
endinterface

>>> sv/shift_flip_alu_blit_write.sv
// blitter write path: shifter, flopper and 74181 logic unit
// depends on sfab_pkg, sfab_req_if and sfab_res_if
//
// channel  | dir | carries
// ---------+-----+---------------------------------------------------
// i_req    | in  | req_type, address, src_value, old_value
// o_res    | out | write_valid, write_addr, write_value, hit_status
//
// one request per cycle unless a stalled result holds it; each result appears in the cycle after its request,
// from the result register fed by the shift, flip and logic stage
// reset (synchronous, i_rst_n low) clears mode, hit flag and result valid, sets the carry latch
// a stalled result holds in its register; a request is taken whenever the
// register is empty or is being drained in the same cycle

module shift_flip_alu_blit_write #(
    parameter int ADDR_BITS = 13
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sfab_req_if.sink   i_req,
    sfab_res_if.source o_res
);
    import sfab_pkg::*;

    logic [7:0]            r_mode;
    logic [CARRY_BITS-1:0] r_carry;
    logic                  r_hit;

    logic                  r_out_valid;
    logic                  r_write_valid;
    logic [ADDR_BITS-1:0]  r_write_addr;
    logic [7:0]            r_write_value;
    logic                  r_hit_status;

    logic                  accept;
    logic [WORD_BITS-1:0]  word;
    logic [2:0]            shamt;
    logic [WORD_BITS-1:0]  shifted;
    logic [SHIFT_BITS-1:0] s_bits;
    logic [7:0]            t_pick;
    logic [7:0]            t_val;
    logic [7:0]            alu_f;
    logic                  overlap;

    logic [7:0]            n_mode;
    logic [CARRY_BITS-1:0] n_carry;
    logic                  n_hit;
    logic                  n_write_valid;
    logic [ADDR_BITS-1:0]  n_write_addr;
    logic [7:0]            n_write_value;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    // shift toward lsb by twice the mode field, keep nine bits
    assign word    = {r_carry, i_req.src_value};
    assign shamt   = {r_mode[MODE_SH_HI:MODE_SH_LO], 1'b0};
    assign shifted = word >> shamt;
    assign s_bits  = shifted[SHIFT_BITS-1:0];
    assign t_pick  = r_mode[MODE_HI_SEL] ? s_bits[8:1] : s_bits[7:0];
    assign t_val   = r_mode[MODE_REVERSE] ? rev8(t_pick) : t_pick;
    assign alu_f   = logic181(r_mode[MODE_FN_HI:MODE_FN_LO], t_val, i_req.old_value);
    assign overlap = |(t_val & i_req.old_value);

    always_comb begin
        n_mode        = r_mode;
        n_carry       = r_carry;
        n_hit         = r_hit;
        n_write_valid = 1'b0;
        n_write_addr  = '0;
        n_write_value = '0;
        case (i_req.req_type)
            REQ_CTRL: begin
                n_mode  = i_req.src_value;
                n_carry = '0;
                n_hit   = 1'b0;
            end
            REQ_BLIT: begin
                n_hit         = r_hit | overlap;
                n_carry       = i_req.src_value[CARRY_BITS-1:0];
                n_write_valid = 1'b1;
                n_write_addr  = i_req.address;
                n_write_value = ~alu_f;
            end
            default: begin
                // status read and the unused code change nothing
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_carry     <= CARRY_RESET;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode      <= n_mode;
                r_carry     <= n_carry;
                r_hit       <= n_hit;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_write_valid <= n_write_valid;
            r_write_addr  <= n_write_addr;
            r_write_value <= n_write_value;
            r_hit_status  <= n_hit;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.write_valid = r_write_valid;
    assign o_res.write_addr  = r_write_addr;
    assign o_res.write_value = r_write_value;
    assign o_res.hit_status  = r_hit_status;

endmodule
